### design/pgrep_pkg.sv
`default_nettype none

package pgrep_pkg;

	localparam int PAGE_IN_W   = 16;
	localparam int FRAME_OUT_W = 4;
	localparam int EVICT_OUT_W = 16;
	localparam int TOTAL_W     = 32;
	localparam int CFG_W       = 5;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 56;

	// Register indexes on the configuration port
	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_FRAMES = 1'b1;

	// Replacement policy codes
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	// Input item kinds
	localparam logic KIND_REF   = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_COMMIT
	} pgrep_state_t;

	typedef struct packed {
		logic load_in;
		logic capture;
		logic commit;
	} pgrep_cmd_t;

endpackage

`default_nettype wire

### design/pgrep_ctrl.sv
`default_nettype none

module pgrep_ctrl
	import pgrep_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output pgrep_cmd_t      cmd
);

	pgrep_state_t state_q;
	pgrep_state_t state_nxt;
	logic         out_valid_q;
	logic         out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_LOOK;
			end
			ST_LOOK: state_nxt = ST_COMMIT;
			ST_COMMIT: begin
				if (out_free) state_nxt = s_tvalid ? ST_LOOK : ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_LOOK:   cmd.capture = 1'b1;
			ST_COMMIT: begin
				// take the next item in the update cycle when the result has a slot
				s_tready   = out_free;
				cmd.commit = out_free;
			end
			default: s_tready = 1'b0;
		endcase
		cmd.load_in = s_tvalid && s_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_rose_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result appeared without an update");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || m_tready))
		else $error("update would overwrite a pending result");

	a_no_accept_in_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> !s_tready)
		else $error("transfer accepted during lookup");

	a_capture_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_COMMIT))
		else $error("lookup not followed by update");
`endif

endmodule

`default_nettype wire

### design/pgrep_dp.sv
`default_nettype none

module pgrep_dp
	import pgrep_pkg::*;
#(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS  = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire pgrep_cmd_t           cmd,
	input  wire logic                 s_tuser,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic      [M_TDATA_W-1:0] m_tdata
);

	localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW = $clog2(MAX_FRAMES + 1) > FW ? $clog2(MAX_FRAMES + 1) : FW;
	localparam int XW = CFG_W + 2;

	// configuration
	logic             policy_q;
	logic [CFG_W-1:0] frames_q;

	// input item
	logic                 kind_q;
	logic [PAGE_IN_W-1:0] page_q;

	// table state
	logic [PAGE_BITS-1:0] frame_page_q [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid_q;
	logic [FW-1:0]        rank_q [MAX_FRAMES];
	logic [FW-1:0]        ptr_q;
	logic [TOTAL_W-1:0]   fault_cnt_q;

	// lookup stage
	logic                 hit_s1;
	logic                 empty_s1;
	logic [FW-1:0]        f_s1;
	logic [FW-1:0]        old_rank_s1;
	logic [PAGE_BITS-1:0] evpage_s1;
	logic                 upd_ptr_s1;
	logic [FW-1:0]        next_ptr_s1;

	// result register
	logic                   out_fault_q;
	logic [FRAME_OUT_W-1:0] out_frame_q;
	logic                   out_evv_q;
	logic [EVICT_OUT_W-1:0] out_evpage_q;
	logic [TOTAL_W-1:0]     out_total_q;

	logic [PAGE_BITS-1:0]  page_in;
	logic [XW-1:0]         frames_ext;
	logic [CW-1:0]         n_act;
	logic [MAX_FRAMES-1:0] act;
	logic [MAX_FRAMES-1:0] match;
	logic [MAX_FRAMES-1:0] emp;
	logic [MAX_FRAMES-1:0] lru_ok;
	logic [FW-1:0]         hit_idx;
	logic [FW-1:0]         emp_idx;
	logic [FW-1:0]         lru_idx;
	logic [FW-1:0]         fifo_f;
	logic [FW-1:0]         f_sel;
	logic [CW-1:0]         f_inc;
	logic [TOTAL_W-1:0]    cnt_nxt;

	assign page_in    = PAGE_BITS'(page_q);
	assign frames_ext = XW'(frames_q);

	always_comb begin
		if (frames_q == '0) n_act = CW'(1);
		else if (frames_ext > XW'(MAX_FRAMES)) n_act = CW'(MAX_FRAMES);
		else n_act = CW'(frames_ext);
	end

	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			act[i]   = CW'(i) < n_act;
			match[i] = act[i] && valid_q[i] && (frame_page_q[i] == page_in);
			emp[i]   = act[i] && !valid_q[i];
		end
	end

	// an active frame is least recent when its rank is below every other active rank
	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			lru_ok[i] = act[i];
			for (int j = 0; j < MAX_FRAMES; j++) begin
				if (j != i && act[j] && !(rank_q[i] < rank_q[j])) lru_ok[i] = 1'b0;
			end
		end
	end

	always_comb begin
		hit_idx = '0;
		emp_idx = '0;
		lru_idx = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (match[i])  hit_idx = FW'(i);
			if (emp[i])    emp_idx = FW'(i);
			if (lru_ok[i]) lru_idx = FW'(i);
		end
	end

	assign fifo_f = (CW'(ptr_q) < n_act) ? ptr_q : '0;

	always_comb begin
		if (|match) f_sel = hit_idx;
		else if (|emp) f_sel = emp_idx;
		else if (policy_q == POLICY_LRU) f_sel = lru_idx;
		else f_sel = fifo_f;
	end

	assign f_inc   = CW'(f_sel) + CW'(1);
	assign cnt_nxt = (fault_cnt_q == '1) ? fault_cnt_q : fault_cnt_q + TOTAL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_FIFO;
			frames_q <= FRAMES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLICY: policy_q <= cfg_wdata[0];
				REG_FRAMES: frames_q <= cfg_wdata;
				default:    policy_q <= policy_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= s_tuser;
			page_q <= s_tdata;
		end
		if (cmd.capture) begin
			hit_s1      <= |match;
			empty_s1    <= |emp;
			f_s1        <= f_sel;
			old_rank_s1 <= rank_q[f_sel];
			evpage_s1   <= frame_page_q[f_sel];
			upd_ptr_s1  <= !(|match) && ((|emp) || (policy_q == POLICY_FIFO));
			next_ptr_s1 <= (f_inc < n_act) ? FW'(f_inc) : '0;
		end
		if (cmd.commit && kind_q == KIND_REF && !hit_s1) frame_page_q[f_s1] <= page_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			ptr_q       <= '0;
			fault_cnt_q <= '0;
			for (int i = 0; i < MAX_FRAMES; i++) rank_q[i] <= FW'(i);
		end else if (cmd.commit) begin
			if (kind_q == KIND_CLEAR) begin
				valid_q     <= '0;
				ptr_q       <= '0;
				fault_cnt_q <= '0;
				for (int i = 0; i < MAX_FRAMES; i++) rank_q[i] <= FW'(i);
			end else begin
				if (!hit_s1) begin
					valid_q[f_s1] <= 1'b1;
					fault_cnt_q   <= cnt_nxt;
				end
				if (upd_ptr_s1) ptr_q <= next_ptr_s1;
				// make the used frame most recent, close the gap it leaves
				for (int i = 0; i < MAX_FRAMES; i++) begin
					if (FW'(i) == f_s1) rank_q[i] <= FW'(MAX_FRAMES - 1);
					else if (rank_q[i] > old_rank_s1) rank_q[i] <= rank_q[i] - FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (kind_q == KIND_CLEAR) begin
				out_fault_q  <= 1'b0;
				out_frame_q  <= '0;
				out_evv_q    <= 1'b0;
				out_evpage_q <= '0;
				out_total_q  <= '0;
			end else begin
				out_fault_q  <= !hit_s1;
				out_frame_q  <= FRAME_OUT_W'(f_s1);
				out_evv_q    <= !hit_s1 && !empty_s1;
				out_evpage_q <= (!hit_s1 && !empty_s1) ? EVICT_OUT_W'(evpage_s1) : '0;
				out_total_q  <= hit_s1 ? fault_cnt_q : cnt_nxt;
			end
		end
	end

	assign m_tdata = {2'b00, out_total_q, out_evpage_q, out_evv_q, out_frame_q, out_fault_q};

endmodule

`default_nettype wire

### design/page_replacement_fifo_lru_top.sv
// Fully associative page-frame table with FIFO (round-robin) or true LRU replacement.
// Each item passes a lookup state, which compares the page against all active frames in
// parallel and selects the frame (hit, lowest empty frame, or victim), and an update state,
// which updates frames, recency ranks, pointer and fault count and loads the output register.
// The next item is accepted in that update state, so the block takes a new item before it is
// through with the last; the update waits while the output register still holds a result
// that has not been taken. Write configuration only while the block is idle.
`default_nettype none

module page_replacement_fifo_lru_top
	import pgrep_pkg::*;
#(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS  = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // [15:0] page_number
	input  wire logic                 s_tuser,  // [0] kind
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [0] fault, [4:1] frame_index, [5] evicted_valid, [21:6] evicted_page,
	// [53:22] fault_total, [55:54] zero
	output logic      [M_TDATA_W-1:0] m_tdata
);

	pgrep_cmd_t cmd;

	pgrep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	pgrep_dp #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
